>>> hdl/msfd_pkg.sv
// Package for the motor speed frame decoder.
// Holds the frame constants and the sign-magnitude decode function.
// No dependencies.
package msfd_pkg;

    localparam int FRAME_BYTES   = 10;
    localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;
    localparam int POS_W         = 4;
    localparam int SLOT_W        = $clog2(PAYLOAD_BYTES);

    localparam logic [7:0] START_BYTE = 8'h24;
    localparam logic [7:0] STOP_BYTE  = 8'h21;

    localparam logic [POS_W-1:0] POS_SEARCH = POS_W'(0);
    localparam logic [POS_W-1:0] POS_STOP   = POS_W'(FRAME_BYTES - 1);

    function automatic logic signed [15:0] sm_to_speed(input logic [7:0] hi,
                                                       input logic [7:0] lo);
        logic [15:0] mag;
        mag = {1'b0, hi[6:0], lo};
        if (hi[7]) begin
            return $signed(16'(~mag + 16'd1));
        end
        return $signed(mag);
    endfunction

endpackage

>>> hdl/motor_speed_frame_decoder_top.sv
// Motor speed frame decoder, top level.
// Deframes '$', four sign-magnitude words, '!' into four signed speeds.
// Depends on msfd_pkg.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------
//   byte    | in        | s_valid, s_ready, s_rx_byte
//   speeds  | out       | m_valid, m_ready, m_left_speed, m_right_speed,
//           |           | m_left_speed_b, m_right_speed_b
//
// One byte per cycle while s_ready is high; the edge that accepts a good stop
// byte loads the output register, so m_valid rises in the cycle after that transfer.
// Reset clears the frame position and the output valid; payload bytes
// are not cleared.
// s_ready drops only while a stop byte is expected and a result is still
// stalled in the output register.
module motor_speed_frame_decoder_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_left_speed,
    output logic signed [15:0]  m_right_speed,
    output logic signed [15:0]  m_left_speed_b,
    output logic signed [15:0]  m_right_speed_b
);
    import msfd_pkg::*;

    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [7:0]              payload_reg [PAYLOAD_BYTES];
    logic                    m_valid_reg, m_valid_next;
    logic signed [15:0]      speed_reg [4];
    logic                    s_xfer;
    logic                    at_stop;
    logic                    at_payload;
    logic                    frame_good;
    logic [SLOT_W-1:0]       slot;

    assign at_stop    = (pos_reg >= POS_STOP);
    assign at_payload = (pos_reg != POS_SEARCH) && !at_stop;
    assign slot       = SLOT_W'(pos_reg - POS_W'(1));
    assign s_ready    = !(at_stop && m_valid_reg && !m_ready);
    assign s_xfer     = s_valid && s_ready;
    assign frame_good = s_xfer && at_stop && (s_rx_byte == STOP_BYTE);

    always_comb begin
        pos_next = pos_reg;
        if (s_xfer) begin
            priority if (pos_reg == POS_SEARCH) begin
                pos_next = (s_rx_byte == START_BYTE) ? POS_W'(1) : POS_SEARCH;
            end else if (at_payload) begin
                pos_next = pos_reg + POS_W'(1);
            end else begin
                pos_next = POS_SEARCH;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (frame_good) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_SEARCH;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && at_payload) begin
            payload_reg[slot] <= s_rx_byte;
        end
        if (frame_good) begin
            for (int k = 0; k < 4; k++) begin
                speed_reg[k] <= sm_to_speed(payload_reg[2*k], payload_reg[2*k+1]);
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_left_speed    = speed_reg[0];
    assign m_right_speed   = speed_reg[1];
    assign m_left_speed_b  = speed_reg[2];
    assign m_right_speed_b = speed_reg[3];

endmodule

>>> hdl/msfd_checker.sv
// Port-level checker for the motor speed frame decoder, and its bind.
// Depends on msfd_pkg and motor_speed_frame_decoder_top.
module msfd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [7:0]         s_rx_byte,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_left_speed,
    input logic signed [15:0] m_right_speed,
    input logic signed [15:0] m_left_speed_b,
    input logic signed [15:0] m_right_speed_b
);
    import msfd_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_needs_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_rx_byte == STOP_BYTE))
        else $error("result without a stop byte transfer");

    a_no_neg_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_left_speed != 16'sh8000 && m_right_speed != 16'sh8000 &&
                     m_left_speed_b != 16'sh8000 && m_right_speed_b != 16'sh8000))
        else $error("speed outside sign-magnitude range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_left_speed) && $stable(m_right_speed) &&
                                $stable(m_left_speed_b) && $stable(m_right_speed_b))
        else $error("result changed while stalled");

endmodule

bind motor_speed_frame_decoder_top msfd_checker u_msfd_checker (.*);

>>> verif/tb.sv
// Testbench for motor_speed_frame_decoder_top: drives framed byte streams with
// random gaps and stalls; checks each speed set by its deframer or a typed row.
// Depends on msfd_pkg and motor_speed_frame_decoder_top.
module tb;
    import msfd_pkg::*;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] left_b;
        logic signed [15:0] right_b;
    } speed_set_t;

    typedef struct packed {
        logic [7:0] rx;
        bit         typed;
        speed_set_t want;
    } byte_row_t;

    localparam int FRAME_TARGET = 1550;
    localparam int HOLD_AT      = 20;
    localparam int HOLD_CYCLES  = 300;

    localparam byte_row_t DIRECTED [23] = '{
        '{8'h00, 1'b0, '0},
        '{8'hff, 1'b0, '0},
        '{START_BYTE, 1'b0, '0},
        '{8'h7f, 1'b0, '0}, '{8'hff, 1'b0, '0},
        '{8'hff, 1'b0, '0}, '{8'hff, 1'b0, '0},
        '{8'h80, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
        '{STOP_BYTE, 1'b1, '{16'sd32767, -16'sd32767, 16'sd0, 16'sd1}},
        '{START_BYTE, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h80, 1'b0, '0}, '{8'h01, 1'b0, '0},
        '{8'h12, 1'b0, '0}, '{8'h34, 1'b0, '0},
        '{8'hf2, 1'b0, '0}, '{8'h34, 1'b0, '0},
        '{START_BYTE, 1'b0, '0},
        '{STOP_BYTE, 1'b0, '0}
    };

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [7:0]        s_rx_byte;
    logic              m_valid;
    logic              m_ready;
    logic signed [15:0] m_left_speed;
    logic signed [15:0] m_right_speed;
    logic signed [15:0] m_left_speed_b;
    logic signed [15:0] m_right_speed_b;

    logic [POS_W-1:0] frame_pos;
    logic [7:0]       value_bytes [PAYLOAD_BYTES];
    speed_set_t       speeds_due [$];
    int               errors;
    int               bytes_accepted;
    int               speeds_seen;

    motor_speed_frame_decoder_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_left_speed    (m_left_speed),
        .m_right_speed   (m_right_speed),
        .m_left_speed_b  (m_left_speed_b),
        .m_right_speed_b (m_right_speed_b)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(20 * 200_000);
        $display("tb NOT OK");
        $finish;
    end

    function automatic logic signed [15:0] word_from_sm(input logic [7:0] hi,
                                                        input logic [7:0] lo);
        logic signed [15:0] mag;
        mag = {1'b0, hi[6:0], lo};
        return hi[7] ? -mag : mag;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output speed_set_t s);
        s = '0;
        if (frame_pos == POS_SEARCH) begin
            if (b == START_BYTE) frame_pos = POS_W'(1);
            return 1'b0;
        end
        if (frame_pos <= PAYLOAD_BYTES) begin
            value_bytes[SLOT_W'(frame_pos - POS_W'(1))] = b;
            frame_pos = frame_pos + 1'b1;
            return 1'b0;
        end
        frame_pos = POS_SEARCH;
        if (b != STOP_BYTE) return 1'b0;
        s.left    = word_from_sm(value_bytes[0], value_bytes[1]);
        s.right   = word_from_sm(value_bytes[2], value_bytes[3]);
        s.left_b  = word_from_sm(value_bytes[4], value_bytes[5]);
        s.right_b = word_from_sm(value_bytes[6], value_bytes[7]);
        return 1'b1;
    endfunction

    function automatic void check_field(input string field,
                                        input logic signed [15:0] want,
                                        input logic signed [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    function automatic logic [7:0] pick_value_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h7f;
            3: return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Enter and leave at a falling edge.
    task automatic send_byte(input logic [7:0] b, input bit typed, input speed_set_t want);
        int         gap;
        speed_set_t got;
        gap = ((bytes_accepted / 100) % 4 == 3) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_accepted++;
        if (deframe_byte(b, got)) speeds_due.push_back(typed ? want : got);
        @(negedge aclk);
    endtask

    initial begin
        speed_set_t none;
        logic [7:0] b;
        int         frame_bytes;
        none        = '0;
        frame_bytes = 0;
        errors      = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_rx_byte   = 8'h00;
        frame_pos   = POS_SEARCH;
        bytes_accepted = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < $size(DIRECTED); i++)
            send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);

        while (frame_bytes < FRAME_TARGET) begin
            case ($urandom_range(0, 9))
                0: send_byte(8'($urandom_range(0, 255)), 1'b0, none);
                1: begin
                    send_byte(START_BYTE, 1'b0, none);
                    for (int k = 0; k < PAYLOAD_BYTES; k++)
                        send_byte(pick_value_byte(), 1'b0, none);
                    b = 8'($urandom_range(0, 255));
                    if (b == STOP_BYTE) b = ~b;
                    send_byte(b, 1'b0, none);
                    frame_bytes += FRAME_BYTES;
                end
                default: begin
                    send_byte(START_BYTE, 1'b0, none);
                    for (int k = 0; k < PAYLOAD_BYTES; k++)
                        send_byte(pick_value_byte(), 1'b0, none);
                    send_byte(STOP_BYTE, 1'b0, none);
                    frame_bytes += FRAME_BYTES;
                end
            endcase
        end
        s_valid <= 1'b0;

        while (speeds_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial begin
        speed_set_t want;
        int         stall;
        m_ready     = 1'b0;
        speeds_seen = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (speeds_seen == HOLD_AT)
                stall = HOLD_CYCLES;
            else
                stall = ((speeds_seen / 12) % 4 == 3) ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            speeds_seen++;
            if (speeds_due.size() == 0) begin
                $error("speed set transfer with none expected");
                errors++;
            end else begin
                want = speeds_due.pop_front();
                check_field("left_speed",    want.left,    m_left_speed);
                check_field("right_speed",   want.right,   m_right_speed);
                check_field("left_speed_b",  want.left_b,  m_left_speed_b);
                check_field("right_speed_b", want.right_b, m_right_speed_b);
            end
            @(negedge aclk);
        end
    end

endmodule
